>>> hw/rtl/mi3_pkg.sv
package mi3_pkg;

	localparam int unsigned WORD_BITS  = 32;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned N_ELEM     = 9;
	localparam int unsigned IN_BITS    = N_ELEM * WORD_BITS;
	localparam int unsigned TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned PROD_BITS  = 2 * WORD_BITS;
	localparam int unsigned COF_BITS   = 2 * WORD_BITS + 1;
	localparam int unsigned MAG_BITS   = 2 * WORD_BITS;
	localparam int unsigned DET_BITS   = 3 * WORD_BITS + 1;
	localparam int unsigned DABS_BITS  = 3 * WORD_BITS;
	localparam int unsigned NUM_BITS   = MAG_BITS + 2 * FRAC_BITS;
	localparam int unsigned TOP_BITS   = NUM_BITS - WORD_BITS;
	localparam int unsigned CMP_BITS   = (TOP_BITS > DABS_BITS) ? TOP_BITS : DABS_BITS;
	localparam int unsigned PREP_STAGE = 6;
	localparam int unsigned STAGES     = WORD_BITS + PREP_STAGE + 1;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic        [WORD_BITS-1:0] uword_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [COF_BITS-1:0]  cof_t;
	typedef logic        [MAG_BITS-1:0]  mag_t;
	typedef logic signed [DET_BITS-1:0]  det_t;
	typedef logic        [DABS_BITS-1:0] dabs_t;
	typedef logic        [NUM_BITS-1:0]  num_t;
	typedef logic        [CMP_BITS-1:0]  cmp_t;

	localparam uword_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam uword_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

endpackage

>>> hw/rtl/matrix_inverse_3x3_unit.sv
// channel  | dir | tdata (low bit up)                  | tuser
// s_axis   | in  | a_r0c0 .. a_r2c2, 32 bits each      | -
// m_axis   | out | inv_r0c0 .. inv_r2c2, 32 bits each  | singular
//
// Stages: cofactor products, cofactor sums, two steps of determinant products,
// determinant sum, sign/overflow prep, one quotient bit per stage for 32 stages of
// nine parallel restoring dividers, and the saturating output stage. One input is
// taken per cycle unless stalled. Each stage holds only when its successor is full
// and stalled, so bubbles close up. Reset clears only the valid bits.
module matrix_inverse_3x3_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mi3_pkg::TDATA_BITS-1:0]  s_tdata,  // a_r0c0, a_r0c1, .. a_r2c2
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mi3_pkg::TDATA_BITS-1:0]  m_tdata,  // inv_r0c0, inv_r0c1, .. inv_r2c2
	output logic [0:0]                      m_tuser   // singular
);

	localparam int unsigned W  = mi3_pkg::WORD_BITS;
	localparam int unsigned NE = mi3_pkg::N_ELEM;
	localparam int unsigned NS = mi3_pkg::STAGES;
	localparam int unsigned PS = mi3_pkg::PREP_STAGE;

	logic [NS:1]   vld_s;
	logic [NS:0]   vld_in;
	logic [NS+1:1] adv;

	assign adv[NS+1] = m_tready;
	assign s_tready  = adv[1];
	assign m_tvalid  = vld_s[NS];
	assign vld_in    = {vld_s, s_tvalid};

	for (genvar k = 1; k <= NS; k++) begin : g_ctl
		assign adv[k] = !vld_s[k] || adv[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in[k-1];
			end
		end
	end

	mi3_pkg::word_t mat [NE];
	for (genvar e = 0; e < NE; e++) begin : g_in
		assign mat[e] = mi3_pkg::word_t'(s_tdata[e*W +: W]);
	end

	mi3_pkg::prod_t prod_a_s1 [NE];
	mi3_pkg::prod_t prod_b_s1 [NE];
	mi3_pkg::word_t row0_s1   [3];
	mi3_pkg::word_t row0_s2   [3];
	mi3_pkg::cof_t  cof_s2    [NE];
	mi3_pkg::cof_t  cof_s3    [NE];
	mi3_pkg::cof_t  cof_s4    [NE];
	mi3_pkg::cof_t  cof_s5    [NE];
	mi3_pkg::cof_t  plo_s3    [3];
	mi3_pkg::cof_t  phi_s3    [3];
	mi3_pkg::det_t  term_s4   [3];
	mi3_pkg::det_t  det_s5;

	for (genvar e = 0; e < NE; e++) begin : g_cof
		localparam int R1 = ((e / 3) + 1) % 3;
		localparam int R2 = ((e / 3) + 2) % 3;
		localparam int C1 = ((e % 3) + 1) % 3;
		localparam int C2 = ((e % 3) + 2) % 3;
		always_ff @(posedge clk) begin
			if (adv[1]) begin
				prod_a_s1[e] <= mi3_pkg::prod_t'(mat[R1*3+C1]) * mi3_pkg::prod_t'(mat[R2*3+C2]);
				prod_b_s1[e] <= mi3_pkg::prod_t'(mat[R1*3+C2]) * mi3_pkg::prod_t'(mat[R2*3+C1]);
			end
			if (adv[2]) begin
				cof_s2[e] <= mi3_pkg::cof_t'(prod_a_s1[e]) - mi3_pkg::cof_t'(prod_b_s1[e]);
			end
			if (adv[3]) cof_s3[e] <= cof_s2[e];
			if (adv[4]) cof_s4[e] <= cof_s3[e];
			if (adv[5]) cof_s5[e] <= cof_s4[e];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_det
		logic signed [W:0] lo_ext;
		logic signed [W:0] hi_ext;
		assign lo_ext = $signed({1'b0, cof_s2[j][W-1:0]});
		assign hi_ext = $signed(cof_s2[j][mi3_pkg::COF_BITS-1:W]);
		always_ff @(posedge clk) begin
			if (adv[1]) row0_s1[j] <= mat[j];
			if (adv[2]) row0_s2[j] <= row0_s1[j];
			if (adv[3]) begin
				plo_s3[j] <= mi3_pkg::cof_t'(row0_s2[j]) * mi3_pkg::cof_t'(lo_ext);
				phi_s3[j] <= mi3_pkg::cof_t'(row0_s2[j]) * mi3_pkg::cof_t'(hi_ext);
			end
			if (adv[4]) begin
				term_s4[j] <= (mi3_pkg::det_t'(phi_s3[j]) <<< W) + mi3_pkg::det_t'(plo_s3[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
	end

	// divider pipeline, index 0 is the prep stage
	mi3_pkg::dabs_t dabs_s  [0:W];
	logic           zero_s  [0:W];
	mi3_pkg::dabs_t rem_s   [0:W][NE];
	mi3_pkg::uword_t low_s  [0:W][NE];
	mi3_pkg::uword_t quo_s  [0:W][NE];
	logic           ovf_s   [0:W][NE];
	logic           neg_s   [0:W][NE];

	logic           det_neg;
	mi3_pkg::det_t  det_abs;
	assign det_neg = det_s5[mi3_pkg::DET_BITS-1];
	assign det_abs = det_neg ? -det_s5 : det_s5;

	always_ff @(posedge clk) begin
		if (adv[PS]) begin
			dabs_s[0] <= mi3_pkg::dabs_t'(det_abs);
			zero_s[0] <= (det_s5 == '0);
		end
	end

	for (genvar e = 0; e < NE; e++) begin : g_prep
		logic            cneg;
		mi3_pkg::cof_t   cabs;
		mi3_pkg::num_t   num;
		logic            ovf;
		assign cneg = cof_s5[e][mi3_pkg::COF_BITS-1];
		assign cabs = cneg ? -cof_s5[e] : cof_s5[e];
		assign num  = mi3_pkg::num_t'(mi3_pkg::mag_t'(cabs)) << (2 * mi3_pkg::FRAC_BITS);
		assign ovf  = mi3_pkg::cmp_t'(num[mi3_pkg::NUM_BITS-1:W])
			>= mi3_pkg::cmp_t'(mi3_pkg::dabs_t'(det_abs));
		always_ff @(posedge clk) begin
			if (adv[PS]) begin
				rem_s[0][e] <= mi3_pkg::dabs_t'(num[mi3_pkg::NUM_BITS-1:W]);
				low_s[0][e] <= num[W-1:0];
				quo_s[0][e] <= '0;
				ovf_s[0][e] <= ovf;
				neg_s[0][e] <= cneg ^ det_neg;
			end
		end
	end

	for (genvar d = 1; d <= W; d++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[PS+d]) begin
				dabs_s[d] <= dabs_s[d-1];
				zero_s[d] <= zero_s[d-1];
			end
		end
		for (genvar e = 0; e < NE; e++) begin : g_el
			logic [mi3_pkg::DABS_BITS:0] trial;
			logic [mi3_pkg::DABS_BITS:0] diff;
			logic                        ge;
			assign trial = {rem_s[d-1][e], low_s[d-1][e][W-1]};
			assign diff  = trial - {1'b0, dabs_s[d-1]};
			assign ge    = trial >= {1'b0, dabs_s[d-1]};
			always_ff @(posedge clk) begin
				if (adv[PS+d]) begin
					rem_s[d][e] <= ge ? diff[mi3_pkg::DABS_BITS-1:0]
						: trial[mi3_pkg::DABS_BITS-1:0];
					low_s[d][e] <= low_s[d-1][e] << 1;
					quo_s[d][e] <= {quo_s[d-1][e][W-2:0], ge};
					ovf_s[d][e] <= ovf_s[d-1][e];
					neg_s[d][e] <= neg_s[d-1][e];
				end
			end
		end
	end

	mi3_pkg::uword_t inv_s [NE];
	logic            sing_s;

	always_ff @(posedge clk) begin
		if (adv[NS]) sing_s <= zero_s[W];
	end

	for (genvar o = 0; o < NE; o++) begin : g_out
		localparam int SRC = (o % 3) * 3 + (o / 3);
		mi3_pkg::uword_t q;
		mi3_pkg::uword_t res;
		assign q = quo_s[W][SRC];
		always_comb begin
			if (zero_s[W]) begin
				res = '0;
			end else if (neg_s[W][SRC]) begin
				res = (ovf_s[W][SRC] || (q > mi3_pkg::WORD_MIN)) ? mi3_pkg::WORD_MIN : -q;
			end else begin
				res = (ovf_s[W][SRC] || q[W-1]) ? mi3_pkg::WORD_MAX : q;
			end
		end
		always_ff @(posedge clk) begin
			if (adv[NS]) inv_s[o] <= res;
		end
		assign m_tdata[o*W +: W] = inv_s[o];
	end

	if (mi3_pkg::TDATA_BITS > mi3_pkg::IN_BITS) begin : g_pad
		assign m_tdata[mi3_pkg::TDATA_BITS-1:mi3_pkg::IN_BITS] = '0;
	end

	assign m_tuser[0] = sing_s;

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("singular result carries nonzero data");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s == '0 |-> s_tready)
		else $error("empty pipeline refuses input");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[PS+1] && !zero_s[1] && !ovf_s[1][0] |-> rem_s[1][0] < dabs_s[1])
		else $error("divider remainder out of range");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && !adv[NS] |=> vld_s[NS-1])
		else $error("stalled stage dropped its item");

endmodule
